FILE: design/b64enc_pkg.sv
// Package for the base64 stream encoder: group record, ASCII constants and
// the sextet-to-character mapping. No dependencies.
`default_nettype none

package b64enc_pkg;

    localparam int QUEUE_DEPTH = 2;

    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_LOWER_A = 8'h61;
    localparam logic [7:0] CHAR_DIGIT_0 = 8'h30;
    localparam logic [7:0] CHAR_PLUS    = 8'h2B;
    localparam logic [7:0] CHAR_SLASH   = 8'h2F;
    localparam logic [7:0] PAD_CHAR     = 8'h3D;

    localparam logic [5:0] SEXTET_LOWER = 6'd26;
    localparam logic [5:0] SEXTET_DIGIT = 6'd52;
    localparam logic [5:0] SEXTET_PLUS  = 6'd62;

    localparam logic [1:0] NBYTES_ONE   = 2'd1;
    localparam logic [1:0] NBYTES_TWO   = 2'd2;
    localparam logic [1:0] NBYTES_THREE = 2'd3;

    // One group handed from the front to the back.
    typedef struct packed {
        logic [23:0] bits;
        logic [1:0]  nbytes;
        logic        eom;
    } t_group;

    function automatic logic [7:0] b64_char(input logic [5:0] v);
        logic [7:0] ext;
        ext = {2'b00, v};
        if (v < SEXTET_LOWER) begin
            return CHAR_UPPER_A + ext;
        end else if (v < SEXTET_DIGIT) begin
            return CHAR_LOWER_A + ext - {2'b00, SEXTET_LOWER};
        end else if (v < SEXTET_PLUS) begin
            return CHAR_DIGIT_0 + ext - {2'b00, SEXTET_DIGIT};
        end else if (v == SEXTET_PLUS) begin
            return CHAR_PLUS;
        end else begin
            return CHAR_SLASH;
        end
    endfunction

endpackage

`default_nettype wire

FILE: design/b64enc_if.sv
// Valid/ready channel interfaces of the base64 encoder: raw byte requests in,
// character requests out. No dependencies.
`default_nettype none

interface b64enc_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       end_of_message;
    modport source (output valid, in_byte, end_of_message, input ready);
    modport sink   (input valid, in_byte, end_of_message, output ready);
endinterface

interface b64enc_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_char;
    logic       last_char;
    modport source (output valid, out_char, last_char, input ready);
    modport sink   (input valid, out_char, last_char, output ready);
endinterface

`default_nettype wire

FILE: design/b64enc_front.sv
// Front of the base64 encoder: gathers bytes into groups of up to three and
// pushes each complete or final group. Uses b64enc_pkg and b64enc_if.
`default_nettype none

module b64enc_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    b64enc_byte_if.sink        i_in,
    input  wire logic          i_q_full,
    output logic               o_push,
    output b64enc_pkg::t_group o_group
);

    logic [15:0] r_pend;
    logic [1:0]  r_cnt;
    logic [15:0] n_pend;
    logic [1:0]  n_cnt;
    logic [1:0]  held;
    logic        emit;
    logic        accept;

    always_comb begin
        held   = (r_cnt == 2'd3) ? 2'd2 : r_cnt;
        emit   = i_in.end_of_message || (held == 2'd2);
        i_in.ready = !i_q_full || !emit;
        accept = i_in.valid && i_in.ready;
        o_push = accept && emit;

        case (held)
            2'd0: o_group.bits = {i_in.in_byte, 16'h0000};
            2'd1: o_group.bits = {r_pend[15:8], i_in.in_byte, 8'h00};
            default: o_group.bits = {r_pend, i_in.in_byte};
        endcase
        o_group.nbytes = held + 2'd1;
        o_group.eom    = i_in.end_of_message;

        n_pend = r_pend;
        n_cnt  = r_cnt;
        if (accept) begin
            if (emit) begin
                n_pend = 16'h0000;
                n_cnt  = 2'd0;
            end else begin
                if (held == 2'd0) begin
                    n_pend = {i_in.in_byte, 8'h00};
                end else begin
                    n_pend = {r_pend[15:8], i_in.in_byte};
                end
                n_cnt = held + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= 16'h0000;
            r_cnt  <= 2'd0;
        end else begin
            r_pend <= n_pend;
            r_cnt  <= n_cnt;
        end
    end

endmodule

`default_nettype wire

FILE: design/b64enc_queue.sv
// Short group queue between the encoder front and back.
// Uses b64enc_pkg.
`default_nettype none

module b64enc_queue #(
    parameter int P_DEPTH = b64enc_pkg::QUEUE_DEPTH
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_push,
    input  wire b64enc_pkg::t_group i_group,
    output logic                    o_full,
    output logic                    o_valid,
    output b64enc_pkg::t_group      o_group,
    input  wire logic               i_pop
);

    localparam int PTR_W = $clog2(P_DEPTH);
    localparam int CNT_W = $clog2(P_DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(P_DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(P_DEPTH);

    b64enc_pkg::t_group r_mem [P_DEPTH];
    logic [PTR_W-1:0]   r_wp;
    logic [PTR_W-1:0]   r_rp;
    logic [CNT_W-1:0]   r_cnt;
    logic               do_pop;

    assign o_full  = (r_cnt == FULL_CNT);
    assign o_valid = (r_cnt != '0);
    assign o_group = r_mem[r_rp];
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (i_push && !o_full) begin
            r_mem[r_wp] <= i_group;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push && !o_full) begin
                r_wp <= (r_wp == LAST_PTR) ? '0 : r_wp + PTR_W'(1);
            end
            if (do_pop) begin
                r_rp <= (r_rp == LAST_PTR) ? '0 : r_rp + PTR_W'(1);
            end
            case ({i_push && !o_full, do_pop})
                2'b10:   r_cnt <= r_cnt + CNT_W'(1);
                2'b01:   r_cnt <= r_cnt - CNT_W'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

`default_nettype wire

FILE: design/b64enc_back.sv
// Back of the base64 encoder: serializes each queued group into four
// characters, one per cycle while the sink is ready, through an output
// register. Uses b64enc_pkg and b64enc_if.
`default_nettype none

module b64enc_back (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_q_valid,
    input  wire b64enc_pkg::t_group i_group,
    output logic                    o_pop,
    b64enc_char_if.source           o_out
);

    logic       r_valid;
    logic [7:0] r_char;
    logic       r_last;
    logic [1:0] r_ph;
    logic       load;
    logic [5:0] sextet;
    logic       pad;
    logic [7:0] n_char;

    always_comb begin
        load  = i_q_valid && (!r_valid || o_out.ready);
        o_pop = load && (r_ph == 2'd3);
        case (r_ph)
            2'd0:    sextet = i_group.bits[23:18];
            2'd1:    sextet = i_group.bits[17:12];
            2'd2:    sextet = i_group.bits[11:6];
            default: sextet = i_group.bits[5:0];
        endcase
        pad = ((r_ph == 2'd2) && (i_group.nbytes == b64enc_pkg::NBYTES_ONE))
           || ((r_ph == 2'd3) && (i_group.nbytes != b64enc_pkg::NBYTES_THREE));
        n_char = pad ? b64enc_pkg::PAD_CHAR : b64enc_pkg::b64_char(sextet);
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_char <= n_char;
            r_last <= i_group.eom && (r_ph == 2'd3);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_ph    <= 2'd0;
        end else if (load) begin
            r_valid <= 1'b1;
            r_ph    <= r_ph + 2'd1;
        end else if (o_out.ready) begin
            r_valid <= 1'b0;
        end
    end

    assign o_out.valid     = r_valid;
    assign o_out.out_char  = r_char;
    assign o_out.last_char = r_last;

endmodule

`default_nettype wire

FILE: design/base64_stream_encoder.sv
// Top level of the base64 stream encoder (RFC 4648 standard alphabet).
// Uses b64enc_pkg, b64enc_if, b64enc_front, b64enc_queue, b64enc_back.
`default_nettype none

// Bytes enter one per request with a final-byte flag; every third byte, and
// the final byte, closes a group that the front places into a short queue
// (P_QUEUE_DEPTH groups). The back turns each group into four characters,
// padded with '=' on a short final group, and marks the message's last
// character. A byte is taken every cycle while the queue has room; output
// runs at one character per cycle from a single output register while the
// sink is ready, and the first character of a group passes through the
// queue and then that output register after the byte that closes it.
module base64_stream_encoder #(
    parameter int P_QUEUE_DEPTH = b64enc_pkg::QUEUE_DEPTH
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    b64enc_byte_if.sink   i_in,
    b64enc_char_if.source o_out
);

    logic               push;
    logic               q_full;
    logic               q_valid;
    logic               pop;
    b64enc_pkg::t_group push_group;
    b64enc_pkg::t_group head_group;

    b64enc_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (i_in),
        .i_q_full (q_full),
        .o_push   (push),
        .o_group  (push_group)
    );

    b64enc_queue #(
        .P_DEPTH (P_QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_group (push_group),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_group (head_group),
        .i_pop   (pop)
    );

    b64enc_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_group   (head_group),
        .o_pop     (pop),
        .o_out     (o_out)
    );

endmodule

`default_nettype wire

FILE: design/b64enc_checker.sv
// Port-level checks for base64_stream_encoder, attached by bind.
// Uses b64enc_pkg.
`default_nettype none

module b64enc_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_out_valid,
    input wire logic       i_out_ready,
    input wire logic [7:0] i_out_char,
    input wire logic       i_out_last
);

    logic [1:0] r_pos;
    logic       r_padded;
    logic       take;

    assign take = i_out_valid && i_out_ready;

    // Position of the next character within its group of four.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos    <= 2'd0;
            r_padded <= 1'b0;
        end else if (take) begin
            r_pos    <= r_pos + 2'd1;
            r_padded <= (r_pos == 2'd2) && (i_out_char == b64enc_pkg::PAD_CHAR);
        end
    end

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid right after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_char)
            && $stable(i_out_last))
        else $error("stalled character changed");

    a_last_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take && i_out_last |-> r_pos == 2'd3)
        else $error("last mark off the fourth character");

    a_pad_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take && (r_pos == 2'd0 || r_pos == 2'd1) |-> i_out_char != b64enc_pkg::PAD_CHAR)
        else $error("padding in the first two characters");

    a_pad_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take && r_padded && r_pos == 2'd3 |-> i_out_char == b64enc_pkg::PAD_CHAR
            && i_out_last)
        else $error("short group not padded to the end of the message");

endmodule

bind base64_stream_encoder b64enc_checker u_b64enc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_char  (o_out.out_char),
    .i_out_last  (o_out.last_char)
);

`default_nettype wire

FILE: tb/sv/base64_stream_encoder_tb.sv
// Testbench for base64_stream_encoder: drives whole messages of raw bytes with
// bursty requests and checks each character against a scoreboard predictor.
// Depends on b64enc_pkg, b64enc_if and the encoder RTL.
`default_nettype none

module base64_stream_encoder_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DIRECTED_BYTES = 25;
    localparam int RANDOM_BYTES   = 225;
    localparam int HOLD_AT_BYTES  = 100;
    localparam int HOLD_CYCLES    = 80;
    localparam int DRAIN_CYCLES   = 16;
    localparam int LIMIT_CYCLES   = 200000;

    class b64_scoreboard;
        typedef struct packed {
            logic [7:0] ch;
            logic       last;
        } t_char_rec;

        t_char_rec   expected_chars[$];
        logic [15:0] held_bytes;
        int          held_count;
        int          errors;
        int          bytes_noted;
        int          messages_noted;
        int          chars_checked;
        string       alphabet;

        function new();
            held_bytes     = '0;
            held_count     = 0;
            errors         = 0;
            bytes_noted    = 0;
            messages_noted = 0;
            chars_checked  = 0;
            alphabet = {"ABCDEFGHIJKLMNOPQRSTUVWXYZ", "abcdefghijklmnopqrstuvwxyz",
                        "0123456789+/"};
        endfunction

        function logic [7:0] sextet_to_ascii(logic [5:0] v);
            return alphabet[v];
        endfunction

        function void push_char(logic [7:0] ch, logic last);
            t_char_rec rec;
            rec.ch   = ch;
            rec.last = last;
            expected_chars = {expected_chars, rec};
        endfunction

        // Accepted byte request: update held group, queue any characters it closes.
        function void note_byte(logic [7:0] b, logic eom);
            logic [23:0] grp;
            int          total;
            bytes_noted++;
            if (eom) messages_noted++;
            if (!eom && held_count < 2) begin
                if (held_count == 0) begin
                    held_bytes = {b, 8'h00};
                end else begin
                    held_bytes[7:0] = b;
                end
                held_count++;
                return;
            end
            case (held_count)
                0: begin
                    grp = {b, 16'h0000};
                end
                1: begin
                    grp = {held_bytes[15:8], b, 8'h00};
                end
                default: begin
                    grp = {held_bytes, b};
                end
            endcase
            total = held_count + 1;
            push_char(sextet_to_ascii(grp[23:18]), 1'b0);
            push_char(sextet_to_ascii(grp[17:12]), 1'b0);
            push_char(total >= 2 ? sextet_to_ascii(grp[11:6]) : b64enc_pkg::PAD_CHAR, 1'b0);
            push_char(total >= 3 ? sextet_to_ascii(grp[5:0]) : b64enc_pkg::PAD_CHAR, eom);
            held_bytes = '0;
            held_count = 0;
        endfunction

        task report(string msg);
            $display("MISMATCH at %0t: %s", $realtime, msg);
            errors++;
        endtask

        task check_char(logic [7:0] ch, logic last);
            t_char_rec want;
            chars_checked++;
            if (expected_chars.size() == 0) begin
                report($sformatf("unexpected char 0x%02h last=%0b", ch, last));
            end else begin
                want = expected_chars.pop_front();
                if (ch !== want.ch) begin
                    report($sformatf("char %0d: got 0x%02h want 0x%02h",
                                     chars_checked, ch, want.ch));
                end
                if (last !== want.last) begin
                    report($sformatf("char %0d: last got %0b want %0b",
                                     chars_checked, last, want.last));
                end
            end
        endtask
    endclass

    logic i_clk;
    logic i_rst_n;
    logic hold_req;
    logic hold_done;
    int   cycles;
    int   burst_left;

    b64enc_byte_if byte_ch ();
    b64enc_char_if char_ch ();

    b64_scoreboard sb = new();

    base64_stream_encoder dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (byte_ch),
        .o_out   (char_ch)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        byte_ch.valid          = 1'b0;
        byte_ch.in_byte        = 8'h00;
        byte_ch.end_of_message = 1'b0;
        char_ch.ready          = 1'b0;
        i_rst_n                = 1'b0;
        hold_req               = 1'b0;
        hold_done              = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES) begin
            $display("Timeout after %0d cycles", cycles);
            $display("Some tests failed");
            $finish;
        end
    end

    initial cycles = 0;

    // Character sink: stall pattern picked from bits [8:6] of the cycle count, plus one long hold-off.
    initial begin
        int hold_left;
        logic [2:0] mode;
        hold_left = 0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            mode = cycles[8:6];
            if (hold_req && !hold_done && hold_left == 0) begin
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                char_ch.ready = 1'b0;
                hold_left--;
                if (hold_left == 0) hold_done = 1'b1;
            end else begin
                case (mode)
                    3'd0, 3'd1: begin
                        char_ch.ready = 1'b1;
                    end
                    3'd6: begin
                        char_ch.ready = ($urandom_range(3) == 0);
                    end
                    3'd7: begin
                        char_ch.ready = cycles[0];
                    end
                    default: begin
                        char_ch.ready = ($urandom_range(2) != 0);
                    end
                endcase
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && char_ch.valid && char_ch.ready) begin
            sb.check_char(char_ch.out_char, char_ch.last_char);
        end
    end

    task send_byte(input logic [7:0] b, input logic eom);
        @(negedge i_clk);
        byte_ch.valid          = 1'b1;
        byte_ch.in_byte        = b;
        byte_ch.end_of_message = eom;
        do @(posedge i_clk); while (!byte_ch.ready);
        sb.note_byte(b, eom);
        if (sb.bytes_noted == HOLD_AT_BYTES) hold_req = 1'b1;
    endtask

    task sender_gap(input int n);
        @(negedge i_clk);
        byte_ch.valid          = 1'b0;
        byte_ch.in_byte        = 8'($urandom);
        byte_ch.end_of_message = 1'($urandom);
        repeat (n - 1) @(negedge i_clk);
    endtask

    // Random-length message with random content; the sender idles in bursts.
    task send_random_message();
        int len;
        int pick;
        pick = $urandom_range(99);
        if (pick < 70) begin
            len = $urandom_range(7, 1);
        end else if (pick < 95) begin
            len = $urandom_range(20, 8);
        end else begin
            len = $urandom_range(48, 30);
        end
        for (int k = 0; k < len; k++) begin
            send_byte(8'($urandom), k == len - 1);
            if (burst_left == 0) begin
                sender_gap($urandom_range(6, 1));
                burst_left = $urandom_range(12, 1);
            end else begin
                burst_left--;
            end
        end
    endtask

    initial begin
        burst_left = 0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b1);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b1);
        sender_gap(3);
        send_byte(8'hFB, 1'b0);
        send_byte(8'hEF, 1'b0);
        send_byte(8'hBE, 1'b1);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b1);
        send_byte(8'h4D, 1'b0);
        send_byte(8'h61, 1'b0);
        send_byte(8'h6E, 1'b0);
        send_byte(8'h00, 1'b1);
        sender_gap(2);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'h01, 1'b0);
        send_byte(8'h7F, 1'b1);
        send_byte(8'h55, 1'b0);
        send_byte(8'hAA, 1'b0);
        send_byte(8'h33, 1'b0);
        send_byte(8'hCC, 1'b0);
        send_byte(8'h0F, 1'b0);
        send_byte(8'hF0, 1'b1);

        while (sb.bytes_noted < DIRECTED_BYTES + RANDOM_BYTES) begin
            send_random_message();
        end
        @(negedge i_clk);
        byte_ch.valid = 1'b0;

        while (sb.expected_chars.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.expected_chars.size() != 0) begin
            sb.report($sformatf("%0d chars never arrived", sb.expected_chars.size()));
        end

        $display("Encoded %0d bytes in %0d messages, %0d chars checked, %0d errors",
                 sb.bytes_noted, sb.messages_noted, sb.chars_checked, sb.errors);
        $display("Sink hold-off of %0d cycles applied: %0b", HOLD_CYCLES, hold_done);
        if (sb.errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
